[src/lsdr_pkg.sv]
// Shared constants, types and helpers for the radix key/label sorter.
`timescale 1ns / 1ps
package lsdr_pkg;

  localparam int MAX_ITEMS = 1024;
  localparam int IDX_W     = $clog2(MAX_ITEMS);
  localparam int CNT_W     = IDX_W + 1;
  localparam int DIGIT_W   = 8;
  localparam int BUCKETS   = 256;
  localparam int BKT_W     = $clog2(BUCKETS);
  localparam int PASSES    = 4;
  localparam int PASS_W    = 2;
  localparam int KEY_W     = 32;
  localparam int LABEL_W   = 10;
  localparam int ITEM_W    = KEY_W + LABEL_W;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_READ = 1'b1;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [LABEL_W-1:0] label;
  } item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RESP,
    ST_CLEAR,
    ST_HIST_RD,
    ST_HIST_BK,
    ST_HIST_WR,
    ST_SCAN_RD,
    ST_SCAN_WR,
    ST_PERM_RD,
    ST_PERM_BK,
    ST_PERM_WR
  } state_t;

  // Pick the digit of a key for a pass, lowest digit first.
  function automatic logic [BKT_W-1:0] digit_of(input logic [KEY_W-1:0] k,
                                                input logic [PASS_W-1:0] pass);
    logic [KEY_W-1:0] sh;
    sh = k >> ({3'b000, pass} * DIGIT_W);
    return sh[BKT_W-1:0];
  endfunction

endpackage

[src/lsdr_if.sv]
// Valid/ready channel interfaces for sorter requests and responses.
`timescale 1ns / 1ps
interface lsdr_in_if;
  import lsdr_pkg::*;
  logic               valid;
  logic               ready;
  logic               mode;
  logic [KEY_W-1:0]   key;
  logic [LABEL_W-1:0] label;
  logic               last;
  logic [IDX_W-1:0]   rank;
  modport source (output valid, mode, key, label, last, rank, input ready);
  modport sink (input valid, mode, key, label, last, rank, output ready);
endinterface

interface lsdr_out_if;
  import lsdr_pkg::*;
  logic               valid;
  logic               ready;
  logic [KEY_W-1:0]   sorted_key;
  logic [LABEL_W-1:0] sorted_label;
  logic               rank_valid;
  logic               overflowed;
  modport source (output valid, sorted_key, sorted_label, rank_valid, overflowed,
                  input ready);
  modport sink (input valid, sorted_key, sorted_label, rank_valid, overflowed,
                output ready);
endinterface

[src/lsdr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module lsdr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

[src/lsd_radix_key_label_sorter_top.sv]
// Top level of the LSD radix sorter: sequencer, buffers and bucket memory.
`timescale 1ns / 1ps
//  channel | dir | fields                                          | item
//  in_ch   | in  | mode key label last rank                        | load or read
//  out_ch  | out | sorted_key sorted_label rank_valid overflowed    | read response
//
//  A load is taken with no wait state; a read holds off the next input item through
//  ST_RESP and while its response waits on out_ch.
//  The load marked last runs four passes; each pass clears the buckets, builds a
//  histogram, scans the buckets (two bucket accesses per bucket) and permutes the
//  items into the other buffer. No input is taken meanwhile.
//  Synchronous reset clears the sequencer, counts and flags; memories hold junk.
//  A response waiting on out_ch blocks the next input item.
module lsd_radix_key_label_sorter_top
  import lsdr_pkg::*;
(
  input logic         clk,
  input logic         rst,
  lsdr_in_if.sink     in_ch,
  lsdr_out_if.source  out_ch
);

  state_t state, state_next;

  logic [CNT_W-1:0]  item_count;
  logic [CNT_W-1:0]  idx;
  logic [CNT_W-1:0]  base;
  logic [PASS_W-1:0] pass;
  logic              sort_done;
  logic              overflow_flag;
  logic              rd_ok;

  logic              out_valid;
  logic [KEY_W-1:0]  out_key;
  logic [LABEL_W-1:0] out_label;
  logic              out_ok;
  logic              out_ovf;

  // memory ports
  logic             a_we, a_re, b_we, b_re, k_we, k_re;
  logic [IDX_W-1:0] a_waddr, a_raddr, b_waddr, b_raddr;
  item_t            a_wdata, b_wdata, a_rdata, b_rdata;
  logic [BKT_W-1:0] k_waddr, k_raddr;
  logic [CNT_W-1:0] k_wdata, k_rdata;

  logic             in_fire;
  logic             src_is_a;
  item_t            src_q;
  logic [BKT_W-1:0] src_digit;
  logic [CNT_W-1:0] load_count;
  logic             idx_at_end;
  logic             bkt_at_end;

  assign in_ch.ready = (state == ST_IDLE) && !out_valid;
  assign in_fire     = in_ch.valid && in_ch.ready;

  // Even passes move buffer A into B, odd passes move B back into A.
  assign src_is_a   = !pass[0];
  assign src_q      = src_is_a ? a_rdata : b_rdata;
  assign src_digit  = digit_of(src_q.key, pass);
  assign load_count = sort_done ? '0 : item_count;
  assign idx_at_end = (idx == item_count);
  assign bkt_at_end = (idx == CNT_W'(BUCKETS - 1));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_ch.mode == MODE_READ) begin
            state_next = ST_RESP;
          end else if (in_ch.last) begin
            state_next = ST_CLEAR;
          end
        end
      end
      ST_RESP:    state_next = ST_IDLE;
      ST_CLEAR:   state_next = bkt_at_end ? ST_HIST_RD : ST_CLEAR;
      ST_HIST_RD: state_next = idx_at_end ? ST_SCAN_RD : ST_HIST_BK;
      ST_HIST_BK: state_next = ST_HIST_WR;
      ST_HIST_WR: state_next = ST_HIST_RD;
      ST_SCAN_RD: state_next = ST_SCAN_WR;
      ST_SCAN_WR: state_next = bkt_at_end ? ST_PERM_RD : ST_SCAN_RD;
      ST_PERM_RD: begin
        if (!idx_at_end) begin
          state_next = ST_PERM_BK;
        end else if (pass == PASS_W'(PASSES - 1)) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_CLEAR;
        end
      end
      ST_PERM_BK: state_next = ST_PERM_WR;
      ST_PERM_WR: state_next = ST_PERM_RD;
      default:    state_next = ST_IDLE;
    endcase
  end

  // memory controls
  always_comb begin
    a_we = 1'b0; a_re = 1'b0; b_we = 1'b0; b_re = 1'b0;
    k_we = 1'b0; k_re = 1'b0;
    a_waddr = '0; a_raddr = '0; b_waddr = '0; b_raddr = '0;
    a_wdata = src_q; b_wdata = src_q;
    k_waddr = src_digit; k_raddr = src_digit; k_wdata = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_fire && in_ch.mode == MODE_READ) begin
          a_re    = 1'b1;
          a_raddr = in_ch.rank;
        end else if (in_fire && load_count < CNT_W'(MAX_ITEMS)) begin
          a_we          = 1'b1;
          a_waddr       = load_count[IDX_W-1:0];
          a_wdata.key   = in_ch.key;
          a_wdata.label = in_ch.label;
        end
      end
      ST_CLEAR: begin
        k_we    = 1'b1;
        k_waddr = idx[BKT_W-1:0];
      end
      ST_HIST_RD, ST_PERM_RD: begin
        if (!idx_at_end) begin
          a_re    = src_is_a;
          b_re    = !src_is_a;
          a_raddr = idx[IDX_W-1:0];
          b_raddr = idx[IDX_W-1:0];
        end
      end
      ST_HIST_BK, ST_PERM_BK: k_re = 1'b1;
      ST_HIST_WR: begin
        k_we    = 1'b1;
        k_wdata = k_rdata + CNT_W'(1);
      end
      ST_SCAN_RD: begin
        k_re    = 1'b1;
        k_raddr = idx[BKT_W-1:0];
      end
      ST_SCAN_WR: begin
        k_we    = 1'b1;
        k_waddr = idx[BKT_W-1:0];
        k_wdata = base;
      end
      ST_PERM_WR: begin
        k_we    = 1'b1;
        k_wdata = k_rdata + CNT_W'(1);
        a_we    = !src_is_a;
        b_we    = src_is_a;
        a_waddr = k_rdata[IDX_W-1:0];
        b_waddr = k_rdata[IDX_W-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      item_count    <= '0;
      idx           <= '0;
      base          <= '0;
      pass          <= '0;
      sort_done     <= 1'b0;
      overflow_flag <= 1'b0;
      rd_ok         <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_fire && in_ch.mode == MODE_READ) begin
            rd_ok <= sort_done && ({1'b0, in_ch.rank} < item_count);
          end else if (in_fire) begin
            // a load after a sort opens a new set
            sort_done <= 1'b0;
            if (load_count < CNT_W'(MAX_ITEMS)) begin
              item_count <= load_count + CNT_W'(1);
              overflow_flag <= sort_done ? 1'b0 : overflow_flag;
            end else begin
              item_count    <= load_count;
              overflow_flag <= 1'b1;
            end
            idx  <= '0;
            pass <= '0;
          end
        end
        ST_RESP: begin
          out_valid <= 1'b1;
        end
        ST_CLEAR: begin
          idx <= bkt_at_end ? '0 : idx + CNT_W'(1);
        end
        ST_HIST_RD: begin
          if (idx_at_end) begin
            idx  <= '0;
            base <= '0;
          end
        end
        ST_HIST_WR, ST_PERM_WR: idx <= idx + CNT_W'(1);
        ST_SCAN_WR: begin
          base <= base + k_rdata;
          idx  <= bkt_at_end ? '0 : idx + CNT_W'(1);
        end
        ST_PERM_RD: begin
          if (idx_at_end) begin
            idx  <= '0;
            pass <= pass + PASS_W'(1);
            if (pass == PASS_W'(PASSES - 1)) begin
              sort_done <= 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Response payload: capture the buffer read in ST_RESP, the cycle after the request.
  always_ff @(posedge clk) begin
    if (state == ST_RESP) begin
      out_key   <= rd_ok ? a_rdata.key : '0;
      out_label <= rd_ok ? a_rdata.label : '0;
      out_ok    <= rd_ok;
      out_ovf   <= overflow_flag;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.sorted_key   = out_key;
  assign out_ch.sorted_label = out_label;
  assign out_ch.rank_valid   = out_ok;
  assign out_ch.overflowed   = out_ovf;

  lsdr_ram #(.WIDTH(ITEM_W), .DEPTH(MAX_ITEMS)) u_buf_a (
    .clk(clk), .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
    .re(a_re), .raddr(a_raddr), .rdata(a_rdata)
  );

  lsdr_ram #(.WIDTH(ITEM_W), .DEPTH(MAX_ITEMS)) u_buf_b (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
    .re(b_re), .raddr(b_raddr), .rdata(b_rdata)
  );

  lsdr_ram #(.WIDTH(CNT_W), .DEPTH(BUCKETS)) u_buckets (
    .clk(clk), .we(k_we), .waddr(k_waddr), .wdata(k_wdata),
    .re(k_re), .raddr(k_raddr), .rdata(k_rdata)
  );

endmodule
